### src/infix_expression_evaluator_defines.svh
// Assertion macros used by the expression evaluator back end.
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Implication checked in the same cycle.
`define IEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle.
`define IEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/iee_pkg.sv
// Shared types, constants and the character classifier of the expression evaluator.
package iee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_TIMES = 8'h2A;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_PLUS,
        OP_TIMES,
        OP_OPEN,
        OP_CLOSE,
        OP_OTHER,
        OP_EOI
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_SYNTAX = 2'd1,
        STATUS_DEEP   = 2'd2
    } status_t;

    function automatic cmd_t classify(input logic [7:0] sym, input logic eoi);
        cmd_t       c;
        logic [7:0] offset;
        offset  = sym - CHAR_ZERO;
        c.digit = offset[3:0];
        if (eoi)
        begin
            c.op = OP_EOI;
        end
        else if (sym >= CHAR_ZERO && sym <= CHAR_NINE)
        begin
            c.op = OP_DIGIT;
        end
        else if (sym == CHAR_PLUS)
        begin
            c.op = OP_PLUS;
        end
        else if (sym == CHAR_TIMES)
        begin
            c.op = OP_TIMES;
        end
        else if (sym == CHAR_OPEN)
        begin
            c.op = OP_OPEN;
        end
        else if (sym == CHAR_CLOSE)
        begin
            c.op = OP_CLOSE;
        end
        else
        begin
            c.op = OP_OTHER;
        end
        return c;
    endfunction

endpackage

### src/infix_expression_evaluator.sv
// Top level of the expression evaluator: front end, command queue and back end.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_stall    symbol, end_of_input
//  output    out_valid / out_stall  status, value, error_position
//
// The back end takes each character in its execute state; a closing parenthesis
// also needs the stack read and then the 32 by 32 multiply of the saved product.
// A two-entry queue parts the front end from the back end, and the result register
// lets the next character be taken while a result waits on out_stall.
// Reset clears the control state at once; the level stack needs no clearing pass.
module infix_expression_evaluator
    import iee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         symbol,
    input  logic               end_of_input,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] value,
    output logic [15:0]        error_position
);

    logic push;
    cmd_t push_cmd;
    logic pop;
    logic queue_full;
    logic queue_not_empty;
    cmd_t head;

    iee_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .symbol       (symbol),
        .end_of_input (end_of_input),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    iee_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    iee_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .not_empty      (queue_not_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .value          (value),
        .error_position (error_position)
    );

endmodule

### src/iee_front.sv
// Front end: takes input transactions, classifies each character and pushes it to the queue.
module iee_front
    import iee_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] symbol,
    input  logic       end_of_input,
    input  logic       queue_full,
    output logic       push,
    output cmd_t       push_cmd
);

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;
    assign push_cmd = classify(symbol, end_of_input);

endmodule

### src/iee_queue.sv
// Two-entry queue of classified commands between the front and back ends.
module iee_queue
    import iee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/iee_back.sv
// Back end: evaluates queued commands with the level stack and holds the result register.
`include "infix_expression_evaluator_defines.svh"

module iee_back
    import iee_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  cmd_t                head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic signed [31:0]  value,
    output logic [15:0]         error_position
);

    typedef enum logic [2:0] {
        PH_EXPECT = 3'b001,
        PH_AFTER  = 3'b010,
        PH_DRAIN  = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_MUL  = 2'b10
    } state_t;

    logic [63:0]         stack_mem [STACK_DEPTH];
    logic [63:0]         saved_reg;

    phase_t              phase_reg;
    phase_t              phase_next;
    state_t              state_reg;
    state_t              state_next;
    logic [31:0]         sum_reg;
    logic [31:0]         sum_next;
    logic [31:0]         prod_reg;
    logic [31:0]         prod_next;
    logic [31:0]         inner_reg;
    logic [31:0]         inner_next;
    logic [LVL_W-1:0]    level_reg;
    logic [LVL_W-1:0]    level_next;
    logic [LVL_W-1:0]    level_dec;
    logic [15:0]         count_reg;
    logic [15:0]         count_next;
    logic [15:0]         pos;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [31:0]         value_reg;
    logic [15:0]         epos_reg;

    logic                will_emit;
    status_t             emit_status;
    logic [31:0]         emit_value;
    logic [15:0]         emit_pos;
    logic                stack_push;
    logic                out_free;

    assign pos       = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
    assign level_dec = level_reg - {{(LVL_W-1){1'b0}}, 1'b1};
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = not_empty && (state_reg == ST_EXEC) && (!will_emit || out_free);

    always_comb
    begin
        phase_next  = phase_reg;
        state_next  = ST_EXEC;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        inner_next  = inner_reg;
        level_next  = level_reg;
        count_next  = count_reg;
        will_emit   = 1'b0;
        emit_status = STATUS_SYNTAX;
        emit_value  = 32'd0;
        emit_pos    = pos;
        stack_push  = 1'b0;
        if (head.op == OP_EOI)
        begin
            phase_next = PH_EXPECT;
            sum_next   = 32'd0;
            prod_next  = 32'd1;
            level_next = '0;
            count_next = 16'd0;
            if (phase_reg != PH_DRAIN)
            begin
                will_emit = 1'b1;
                if (phase_reg == PH_AFTER && level_reg == '0)
                begin
                    emit_status = STATUS_OK;
                    emit_value  = sum_reg + prod_reg;
                    emit_pos    = 16'd0;
                end
            end
        end
        else if (phase_reg != PH_DRAIN)
        begin
            count_next = pos;
            if (phase_reg == PH_EXPECT)
            begin
                priority if (head.op == OP_DIGIT)
                begin
                    prod_next  = prod_reg * {28'd0, head.digit};
                    phase_next = PH_AFTER;
                end
                else if (head.op == OP_OPEN && level_reg == LVL_W'(STACK_DEPTH))
                begin
                    phase_next  = PH_DRAIN;
                    will_emit   = 1'b1;
                    emit_status = STATUS_DEEP;
                end
                else if (head.op == OP_OPEN)
                begin
                    stack_push = 1'b1;
                    level_next = level_reg + {{(LVL_W-1){1'b0}}, 1'b1};
                    sum_next   = 32'd0;
                    prod_next  = 32'd1;
                end
                else
                begin
                    phase_next = PH_DRAIN;
                    will_emit  = 1'b1;
                end
            end
            else
            begin
                priority if (head.op == OP_PLUS)
                begin
                    sum_next   = sum_reg + prod_reg;
                    prod_next  = 32'd1;
                    phase_next = PH_EXPECT;
                end
                else if (head.op == OP_TIMES)
                begin
                    phase_next = PH_EXPECT;
                end
                else if (head.op == OP_CLOSE && level_reg != '0)
                begin
                    inner_next = sum_reg + prod_reg;
                    level_next = level_dec;
                    state_next = ST_MUL;
                end
                else
                begin
                    phase_next = PH_DRAIN;
                    will_emit  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_EXPECT;
            state_reg     <= ST_EXEC;
            sum_reg       <= 32'd0;
            prod_reg      <= 32'd1;
            level_reg     <= '0;
            count_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_MUL)
            begin
                sum_reg   <= saved_reg[63:32];
                prod_reg  <= saved_reg[31:0] * inner_reg;
                state_reg <= ST_EXEC;
            end
            else if (pop)
            begin
                phase_reg <= phase_next;
                state_reg <= state_next;
                sum_reg   <= sum_next;
                prod_reg  <= prod_next;
                level_reg <= level_next;
                count_reg <= count_next;
            end
            if (pop && will_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            inner_reg <= inner_next;
        end
        if (pop && will_emit)
        begin
            status_reg <= emit_status;
            value_reg  <= emit_value;
            epos_reg   <= emit_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && stack_push)
        begin
            stack_mem[level_reg[STACK_AW-1:0]] <= {sum_reg, prod_reg};
        end
        saved_reg <= stack_mem[level_dec[STACK_AW-1:0]];
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign value          = value_reg;
    assign error_position = epos_reg;

    `IEE_ASSERT_NOW(a_level_bound, 1'b1, level_reg <= LVL_W'(STACK_DEPTH),
        "nesting level beyond stack depth")
    `IEE_ASSERT_NOW(a_no_pop_in_mul, state_reg == ST_MUL, !pop,
        "command taken while a closing parenthesis is being multiplied")
    `IEE_ASSERT_NOW(a_no_overwrite, pop && will_emit, out_free,
        "result register overwritten while a transaction waits")
    `IEE_ASSERT_NEXT(a_mul_one_cycle, state_reg == ST_MUL, state_reg == ST_EXEC,
        "multiply state held for more than one cycle")
    `IEE_ASSERT_NOW(a_ok_no_position, out_valid_reg && status_reg == STATUS_OK,
        epos_reg == 16'd0, "accepted result carries an error position")

endmodule
